>>> rtl/core/dtw_distance_engine_macros.svh
// Assertion helpers for the DTW engine; expect clk and rst_n in scope.
`ifndef DTW_DISTANCE_ENGINE_MACROS_SVH
`define DTW_DISTANCE_ENGINE_MACROS_SVH

// same-cycle implication
`define DTW_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define DTW_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/core/dtw_pkg.sv
package dtw_pkg;

    localparam int DTW_MAX_LEN     = 128;
    localparam int DTW_SAMPLE_BITS = 16;
    localparam int COST_BITS       = 32;

    typedef logic [COST_BITS-1:0] cost_t;

    localparam cost_t COST_MAX = {COST_BITS{1'b1}};

    // request opcodes
    localparam logic OP_REF  = 1'b0;
    localparam logic OP_TEST = 1'b1;

    // tag that travels with one cell through the datapath
    typedef struct packed {
        logic valid;
        logic head;   // first reference entry
        logic tail;   // final reference entry
    } cell_tag_t;

    // write-back status from the cell datapath
    typedef struct packed {
        logic valid;
        logic tail;
        logic hit;    // saturation on this cell
    } wb_t;

    function automatic cost_t cost_min(input cost_t a, input cost_t b);
        cost_min = (a < b) ? a : b;
    endfunction

endpackage

>>> rtl/core/dtw_if.sv
interface dtw_in_if #(
    parameter int SAMPLE_BITS = dtw_pkg::DTW_SAMPLE_BITS
);
    logic                          valid;
    logic                          ready;
    logic                          op;
    logic signed [SAMPLE_BITS-1:0] sample;
    logic                          last;

    modport source (output valid, output op, output sample, output last, input ready);
    modport sink   (input valid, input op, input sample, input last, output ready);
endinterface

interface dtw_out_if;
    logic                 valid;
    logic                 ready;
    logic [dtw_pkg::COST_BITS-1:0] warp_distance;
    logic                 saturated;

    modport source (output valid, output warp_distance, output saturated, input ready);
    modport sink   (input valid, input warp_distance, input saturated, output ready);
endinterface

>>> rtl/core/dtw_ram.sv
module dtw_ram #(
    parameter int WIDTH  = 16,
    parameter int DEPTH  = 128,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

>>> rtl/core/dtw_cell.sv
module dtw_cell #(
    parameter int MAX_LEN     = dtw_pkg::DTW_MAX_LEN,
    parameter int SAMPLE_BITS = dtw_pkg::DTW_SAMPLE_BITS,
    parameter int ADDR_W      = $clog2(MAX_LEN)
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  dtw_pkg::cell_tag_t       issue,
    input  logic [ADDR_W-1:0]        issue_idx,
    input  logic [SAMPLE_BITS-1:0]   x,
    input  logic                     first_col,
    input  logic [SAMPLE_BITS-1:0]   ref_q,
    input  dtw_pkg::cost_t           col_q,
    output dtw_pkg::wb_t             wb,
    output logic [ADDR_W-1:0]        wb_idx,
    output dtw_pkg::cost_t           wb_cost
);
    import dtw_pkg::*;

    // stage 0: aligned with the memory read latency
    cell_tag_t              tag0_reg;
    logic [ADDR_W-1:0]      idx0_reg;
    // stage 1: local cost and min of left/diagonal
    cell_tag_t              tag1_reg;
    cell_tag_t              tag1_next;
    logic [ADDR_W-1:0]      idx1_reg;
    logic [SAMPLE_BITS-1:0] cost1_reg;
    logic [SAMPLE_BITS-1:0] cost1_next;
    cost_t                  lmin1_reg;
    cost_t                  lmin1_next;
    cost_t                  colq_prev_reg;  // old value of the entry below
    cost_t                  prev_new_reg;   // new value of the entry below
    cost_t                  base;
    logic [COST_BITS:0]     sum;
    logic                   hit;
    cost_t                  new_cost;

    always_comb
    begin
        tag1_next  = tag0_reg;
        cost1_next = (ref_q >= x) ? (ref_q - x) : (x - ref_q);
        lmin1_next = tag0_reg.head ? col_q : cost_min(col_q, colq_prev_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag0_reg <= '0;
            tag1_reg <= '0;
        end
        else
        begin
            tag0_reg <= issue;
            tag1_reg <= tag1_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx0_reg  <= issue_idx;
        idx1_reg  <= idx0_reg;
        cost1_reg <= cost1_next;
        lmin1_reg <= lmin1_next;
        if (tag0_reg.valid)
        begin
            colq_prev_reg <= col_q;
        end
        if (tag1_reg.valid)
        begin
            prev_new_reg <= new_cost;
        end
    end

    always_comb
    begin
        if (first_col)
        begin
            base = tag1_reg.head ? '0 : prev_new_reg;
        end
        else
        begin
            base = tag1_reg.head ? lmin1_reg : cost_min(lmin1_reg, prev_new_reg);
        end
        sum      = {1'b0, base} + {1'b0, COST_BITS'(cost1_reg)};
        hit      = (sum >= {1'b0, COST_MAX});
        new_cost = hit ? COST_MAX : sum[COST_BITS-1:0];
    end

    assign wb.valid = tag1_reg.valid;
    assign wb.tail  = tag1_reg.tail;
    assign wb.hit   = hit;
    assign wb_idx   = idx1_reg;
    assign wb_cost  = new_cost;

endmodule

>>> rtl/core/dtw_distance_engine.sv
// Reference requests are taken while idle; a test request on a complete reference runs one
// column pass over n entries, one cell per cycle, set by the single column-cost memory port
// pair. A test marked last yields a result in a result register, then the output register.
// Asynchronous active-low reset clears control state; the sample and cost memories
// are not cleared and hold no valid data until written.
`include "dtw_distance_engine_macros.svh"

module dtw_distance_engine #(
    parameter int MAX_LEN     = dtw_pkg::DTW_MAX_LEN,
    parameter int SAMPLE_BITS = dtw_pkg::DTW_SAMPLE_BITS
) (
    input logic        clk,
    input logic        rst_n,
    dtw_in_if.sink     samples,
    dtw_out_if.source  results
);
    import dtw_pkg::*;

    localparam int ADDR_W = $clog2(MAX_LEN);
    localparam int LEN_W  = $clog2(MAX_LEN + 1);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RUN  = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    logic [1:0]             state_reg,    state_next;
    logic [LEN_W-1:0]       len_reg,      len_next;
    logic                   complete_reg, complete_next;
    logic                   first_col_reg, first_col_next;
    logic                   sticky_reg,   sticky_next;
    logic [LEN_W-1:0]       rd_idx_reg,   rd_idx_next;
    logic [SAMPLE_BITS-1:0] x_reg;
    logic                   last_reg;
    cost_t                  result_reg;
    logic                   result_sat_reg;
    logic                   out_valid_reg, out_valid_next;
    cost_t                  out_dist_reg;
    logic                   out_sat_reg;

    logic                   accept;
    logic                   ref_load;
    logic                   test_start;
    logic [LEN_W-1:0]       base_len;
    logic                   room;
    logic [LEN_W-1:0]       new_len;
    logic [SAMPLE_BITS-1:0] x_offset;
    logic                   issuing;
    logic                   emit;
    cell_tag_t              issue;
    logic [SAMPLE_BITS-1:0] ref_q;
    cost_t                  col_q;
    wb_t                    wb;
    logic [ADDR_W-1:0]      wb_idx;
    cost_t                  wb_cost;

    assign samples.ready = (state_reg == ST_IDLE);
    assign accept        = samples.valid && samples.ready;
    assign ref_load      = accept && (samples.op == OP_REF);
    assign test_start    = accept && (samples.op == OP_TEST) && complete_reg;

    // offset binary so the absolute difference needs no signed arithmetic
    assign x_offset = {~samples.sample[SAMPLE_BITS-1], samples.sample[SAMPLE_BITS-2:0]};

    // a reference after a complete one starts a fresh sequence
    assign base_len = complete_reg ? '0 : len_reg;
    assign room     = (base_len < LEN_W'(MAX_LEN));
    assign new_len  = base_len + LEN_W'(room);

    assign issuing     = (state_reg == ST_RUN) && (rd_idx_reg != len_reg);
    assign issue.valid = issuing;
    assign issue.head  = (rd_idx_reg == '0);
    assign issue.tail  = (rd_idx_reg == (len_reg - LEN_W'(1)));

    assign emit = (state_reg == ST_DONE) && (!out_valid_reg || results.ready);

    dtw_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (MAX_LEN)
    ) u_ref_ram (
        .clk   (clk),
        .we    (ref_load && room),
        .waddr (base_len[ADDR_W-1:0]),
        .wdata (x_offset),
        .raddr (rd_idx_reg[ADDR_W-1:0]),
        .rdata (ref_q)
    );

    // reads run two entries ahead of write-back, so no entry is read and written together
    dtw_ram #(
        .WIDTH (COST_BITS),
        .DEPTH (MAX_LEN)
    ) u_col_ram (
        .clk   (clk),
        .we    (wb.valid),
        .waddr (wb_idx),
        .wdata (wb_cost),
        .raddr (rd_idx_reg[ADDR_W-1:0]),
        .rdata (col_q)
    );

    dtw_cell #(
        .MAX_LEN     (MAX_LEN),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_cell (
        .clk       (clk),
        .rst_n     (rst_n),
        .issue     (issue),
        .issue_idx (rd_idx_reg[ADDR_W-1:0]),
        .x         (x_reg),
        .first_col (first_col_reg),
        .ref_q     (ref_q),
        .col_q     (col_q),
        .wb        (wb),
        .wb_idx    (wb_idx),
        .wb_cost   (wb_cost)
    );

    always_comb
    begin
        state_next     = state_reg;
        len_next       = len_reg;
        complete_next  = complete_reg;
        first_col_next = first_col_reg;
        sticky_next    = sticky_reg;
        rd_idx_next    = rd_idx_reg;
        out_valid_next = out_valid_reg;

        if (results.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (ref_load)
                begin
                    len_next       = new_len;
                    complete_next  = samples.last && (new_len != '0);
                    first_col_next = 1'b1;
                    sticky_next    = 1'b0;
                end
                else if (test_start)
                begin
                    rd_idx_next = '0;
                    state_next  = ST_RUN;
                end
            end
            ST_RUN:
            begin
                if (issuing)
                begin
                    rd_idx_next = rd_idx_reg + LEN_W'(1);
                end
                if (wb.valid)
                begin
                    sticky_next = sticky_reg | wb.hit;
                    if (wb.tail)
                    begin
                        if (last_reg)
                        begin
                            first_col_next = 1'b1;
                            sticky_next    = 1'b0;
                            state_next     = ST_DONE;
                        end
                        else
                        begin
                            first_col_next = 1'b0;
                            state_next     = ST_IDLE;
                        end
                    end
                end
            end
            ST_DONE:
            begin
                if (emit)
                begin
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            len_reg       <= '0;
            complete_reg  <= 1'b0;
            first_col_reg <= 1'b1;
            sticky_reg    <= 1'b0;
            rd_idx_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            len_reg       <= len_next;
            complete_reg  <= complete_next;
            first_col_reg <= first_col_next;
            sticky_reg    <= sticky_next;
            rd_idx_reg    <= rd_idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (test_start)
        begin
            x_reg    <= x_offset;
            last_reg <= samples.last;
        end
        if (wb.valid && wb.tail)
        begin
            result_reg     <= wb_cost;
            result_sat_reg <= sticky_reg | wb.hit;
        end
        if (emit)
        begin
            out_dist_reg <= result_reg;
            out_sat_reg  <= result_sat_reg;
        end
    end

    assign results.valid         = out_valid_reg;
    assign results.warp_distance = out_dist_reg;
    assign results.saturated     = out_sat_reg;

    `DTW_ASSERT_SAME(a_wb_in_run, wb.valid, state_reg == ST_RUN, "write-back outside a column pass")
    `DTW_ASSERT_SAME(a_wb_in_range, wb.valid, LEN_W'(wb_idx) < len_reg, "write-back beyond reference")
    `DTW_ASSERT_NEXT(a_test_runs, test_start, state_reg == ST_RUN, "test request did not start a pass")
    `DTW_ASSERT_NEXT(a_done_emits, emit, out_valid_reg && (state_reg == ST_IDLE), "result not presented")

endmodule

>>> dv/tb.sv
`timescale 1ns / 100ps

module tb;
    import dtw_pkg::*;

    localparam int DEPTH        = DTW_MAX_LEN;
    localparam int PLAN_ROWS    = 25;
    localparam int PHASE_QUOTA  = 135;
    localparam int DRAIN_CYCLES = 2 * DEPTH + 40;

    localparam logic [15:0] SMP_MIN = 16'h8000;
    localparam logic [15:0] SMP_MAX = 16'h7FFF;

    typedef struct packed {
        cost_t distance;
        logic  sat;
    } warp_result_t;

    typedef struct packed {
        logic        op;
        logic [15:0] smp;
        logic        lst;
        logic [31:0] reps;
        logic        typed;
        cost_t       distance;
        logic        sat;
    } stim_row_t;

    logic clk;
    logic rst_n;

    dtw_in_if  samples_if ();
    dtw_out_if results_if ();

    dtw_distance_engine dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .samples (samples_if),
        .results (results_if)
    );

    // predictor state, samples held in offset binary
    logic [15:0] ref_samples [DEPTH];
    int unsigned ref_count    = 0;
    bit          ref_closed   = 1'b0;
    cost_t       col_cost [DEPTH];
    bit          fresh_column = 1'b1;
    bit          sat_seen     = 1'b0;

    warp_result_t due_distances [$];
    warp_result_t due_head;
    int unsigned  mismatches    = 0;
    int unsigned  live_requests = 0;
    int unsigned  send_idle_pct  = 0;
    int unsigned  recv_stall_pct = 0;

    int unsigned phase_idle  [4] = '{0, 68, 0, 37};
    int unsigned phase_stall [4] = '{0, 0, 68, 37};

    stim_row_t opening_requests [PLAN_ROWS] = '{
        // test request with no reference yet
        '{OP_TEST, 16'd5,    1'b1, 32'd1,     1'b0, 32'd0, 1'b0},
        '{OP_REF,  SMP_MIN,  1'b0, 32'd1,     1'b0, 32'd0, 1'b0},
        // reference still open, so ignored
        '{OP_TEST, 16'd5,    1'b1, 32'd1,     1'b0, 32'd0, 1'b0},
        '{OP_REF,  SMP_MAX,  1'b1, 32'd1,     1'b0, 32'd0, 1'b0},
        '{OP_TEST, 16'd0,    1'b1, 32'd1,     1'b1, 32'd65535, 1'b0},
        '{OP_TEST, SMP_MIN,  1'b0, 32'd1,     1'b0, 32'd0, 1'b0},
        '{OP_TEST, SMP_MAX,  1'b1, 32'd1,     1'b1, 32'd0, 1'b0},
        '{OP_TEST, 16'h1234, 1'b0, 32'd1,     1'b0, 32'd0, 1'b0},
        '{OP_TEST, 16'hEDCC, 1'b0, 32'd1,     1'b0, 32'd0, 1'b0},
        '{OP_TEST, 16'h0F0F, 1'b1, 32'd1,     1'b0, 32'd0, 1'b0},
        // fresh reference over a closed one
        '{OP_REF,  16'd100,  1'b1, 32'd1,     1'b0, 32'd0, 1'b0},
        '{OP_TEST, 16'd100,  1'b1, 32'd1,     1'b1, 32'd0, 1'b0},
        // reference load cuts a test short
        '{OP_TEST, 16'h5555, 1'b0, 32'd1,     1'b0, 32'd0, 1'b0},
        '{OP_REF,  16'd7,    1'b0, 32'd1,     1'b0, 32'd0, 1'b0},
        '{OP_REF,  16'hFFF9, 1'b1, 32'd1,     1'b0, 32'd0, 1'b0},
        '{OP_TEST, 16'd3,    1'b0, 32'd1,     1'b0, 32'd0, 1'b0},
        '{OP_TEST, 16'hAAAA, 1'b1, 32'd1,     1'b0, 32'd0, 1'b0},
        // overlong reference: excess dropped, last mark still closes it
        '{OP_REF,  16'd1234, 1'b0, 32'd129,   1'b0, 32'd0, 1'b0},
        '{OP_REF,  SMP_MIN,  1'b1, 32'd1,     1'b0, 32'd0, 1'b0},
        '{OP_TEST, 16'd1234, 1'b1, 32'd1,     1'b1, 32'd0, 1'b0},
        // full-scale distance accumulated over several columns
        '{OP_REF,  SMP_MIN,  1'b1, 32'd1,     1'b0, 32'd0, 1'b0},
        '{OP_TEST, SMP_MAX,  1'b0, 32'd3,     1'b0, 32'd0, 1'b0},
        '{OP_TEST, SMP_MAX,  1'b1, 32'd1,     1'b1, 32'd262140, 1'b0},
        '{OP_TEST, SMP_MIN,  1'b1, 32'd1,     1'b1, 32'd0, 1'b0},
        '{OP_TEST, 16'hFFFF, 1'b1, 32'd1,     1'b0, 32'd0, 1'b0}
    };

    function automatic longint unsigned sample_gap(input logic [15:0] a, input logic [15:0] b);
        return (a >= b) ? longint'(a - b) : longint'(b - a);
    endfunction

    function automatic cost_t add_clamped(input cost_t base, input longint unsigned add);
        longint unsigned sum;
        sum = longint'(base) + add;
        if (sum >= longint'(COST_MAX))
        begin
            sat_seen = 1'b1;
            return COST_MAX;
        end
        return cost_t'(sum);
    endfunction

    // one request through the model; returns 1 when it yields a distance
    function automatic bit dtw_column_step(input logic op, input logic [15:0] raw,
                                           input logic lst, output warp_result_t res);
        logic [15:0] x;
        cost_t       diag;
        cost_t       left;
        cost_t       best;
        int unsigned i;
        x   = raw ^ 16'h8000;
        res = '0;
        if (op == OP_REF)
        begin
            if (ref_closed)
            begin
                ref_closed = 1'b0;
                ref_count  = 0;
            end
            fresh_column = 1'b1;
            sat_seen     = 1'b0;
            if (ref_count < DEPTH)
            begin
                ref_samples[ref_count] = x;
                ref_count++;
            end
            if (lst)
                ref_closed = 1'b1;
            return 1'b0;
        end
        if (!ref_closed || ref_count == 0)
            return 1'b0;
        diag = col_cost[0];
        col_cost[0] = add_clamped(fresh_column ? cost_t'(0) : col_cost[0],
                                  sample_gap(ref_samples[0], x));
        for (i = 1; i < ref_count; i++)
        begin
            left = col_cost[i];
            if (fresh_column)
                best = col_cost[i-1];
            else
            begin
                best = (left < col_cost[i-1]) ? left : col_cost[i-1];
                if (diag < best)
                    best = diag;
            end
            diag = left;
            col_cost[i] = add_clamped(best, sample_gap(ref_samples[i], x));
        end
        fresh_column = 1'b0;
        if (!lst)
            return 1'b0;
        res.distance = col_cost[ref_count-1];
        res.sat      = sat_seen;
        fresh_column = 1'b1;
        sat_seen     = 1'b0;
        return 1'b1;
    endfunction

    function automatic logic [15:0] pick_sample();
        int unsigned roll;
        roll = $urandom_range(9);
        case (roll)
            0:       return SMP_MIN;
            1:       return SMP_MAX;
            2:       return ($urandom_range(1) != 0) ? 16'hFFFF : 16'h0000;
            3, 4:    return 16'($urandom_range(128)) - 16'd64;
            default: return 16'($urandom);
        endcase
    endfunction

    // called on a clock edge, returns on the edge that accepts the request
    task automatic push_request(input logic op, input logic [15:0] raw, input logic lst,
                                input bit typed, input warp_result_t typed_res);
        warp_result_t got;
        while ($urandom_range(99) < send_idle_pct)
        begin
            samples_if.valid <= 1'b0;
            @(posedge clk);
        end
        samples_if.valid  <= 1'b1;
        samples_if.op     <= op;
        samples_if.sample <= raw;
        samples_if.last   <= lst;
        @(posedge clk);
        while (!samples_if.ready)
            @(posedge clk);
        if (op == OP_REF || ref_closed)
            live_requests++;
        if (dtw_column_step(op, raw, lst, got))
            due_distances.push_back(typed ? typed_res : got);
    endtask

    task automatic run_phase(input int unsigned quota);
        int unsigned stop_at;
        int unsigned len;
        int unsigned k;
        int unsigned roll;
        bit          broken;
        stop_at = live_requests + quota;
        while (live_requests < stop_at)
        begin
            roll = $urandom_range(99);
            if (roll < 6)
                push_request(1'($urandom_range(1)), pick_sample(), 1'($urandom_range(1)),
                             1'b0, '0);
            else if (!ref_closed || roll < 28)
            begin
                roll = $urandom_range(99);
                if (roll < 75)
                    len = $urandom_range(12, 1);
                else if (roll < 95)
                    len = $urandom_range(48, 13);
                else
                    len = $urandom_range(DEPTH + 3, DEPTH - 8);
                for (k = 1; k <= len; k++)
                    push_request(OP_REF, pick_sample(), k == len, 1'b0, '0);
            end
            else
            begin
                len    = $urandom_range(10, 1);
                // now and then leave the test open so the next one carries on its column
                broken = ($urandom_range(99) < 12);
                for (k = 1; k <= len; k++)
                    push_request(OP_TEST, pick_sample(), (k == len) && !broken, 1'b0, '0);
            end
        end
    endtask

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        results_if.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            results_if.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && results_if.valid && results_if.ready)
        begin
            if (due_distances.size() == 0)
            begin
                mismatches++;
                $display("%0t: unexpected result, expected none, got distance %0d sat %0b",
                         $time, results_if.warp_distance, results_if.saturated);
            end
            else
            begin
                due_head = due_distances.pop_front();
                if (results_if.warp_distance !== due_head.distance)
                begin
                    mismatches++;
                    $display("%0t: warp_distance expected %0d, got %0d",
                             $time, due_head.distance, results_if.warp_distance);
                end
                if (results_if.saturated !== due_head.sat)
                begin
                    mismatches++;
                    $display("%0t: saturated expected %0b, got %0b",
                             $time, due_head.sat, results_if.saturated);
                end
            end
        end
    end

    initial
    begin
        int unsigned r;
        int unsigned k;
        int unsigned p;
        samples_if.valid  = 1'b0;
        samples_if.op     = OP_REF;
        samples_if.sample = '0;
        samples_if.last   = 1'b0;
        rst_n = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (r = 0; r < PLAN_ROWS; r++)
            for (k = 0; k < opening_requests[r].reps; k++)
                push_request(opening_requests[r].op, opening_requests[r].smp,
                             opening_requests[r].lst, opening_requests[r].typed,
                             '{distance: opening_requests[r].distance,
                               sat: opening_requests[r].sat});

        for (p = 0; p < 4; p++)
        begin
            send_idle_pct  = phase_idle[p];
            recv_stall_pct = phase_stall[p];
            run_phase(PHASE_QUOTA);
        end
        samples_if.valid <= 1'b0;

        while (due_distances.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    // far beyond every request being a full-length column pass under stalls
    initial
    begin
        #50_000_000;
        $display("Verification failed");
        $finish;
    end

endmodule
